// ===== sv/gdre_pkg.sv =====
// Shared types and constants for the Gaussian density block.
// Used by the front end, divider, scaler, top level and checker; no dependencies.
package gdre_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MEAN_W   = 16;
  localparam int unsigned ESCALE_W = 24;
  localparam int unsigned NSCALE_W = 20;
  localparam int unsigned DENS_W   = 20;

  // Internal datapath widths
  localparam int unsigned MAG_W    = 25;   // clamped |y|, Q.12
  localparam int unsigned NUM_W    = 49;   // numerator / denominator, Q.24
  localparam int unsigned REM_W    = 50;   // partial remainder
  localparam int unsigned RATIO_W  = 17;   // quotient, Q.16, 0..65536
  localparam int unsigned DIV_STEPS    = 17;
  localparam int unsigned FRONT_STAGES = 5;
  localparam int unsigned SCALE_STAGES = 2;

  // Constants of the Pade form
  localparam logic [MAG_W-1:0]  MAG_MAX  = 25'h100_0000;      // 4096.0 in Q.12
  localparam logic [MAG_W-1:0]  THREE_Y  = 25'd12288;         // 3.0 in Q.12
  localparam logic [NUM_W-1:0]  THREE_SQ = 49'h300_0000;      // 3.0 in Q.24
  localparam logic [DENS_W-1:0] DENS_MAX = 20'hF_FFFF;

  // Register word indexes (paddr[3:2])
  localparam logic [1:0] REG_MEAN   = 2'd0;
  localparam logic [1:0] REG_ESCALE = 2'd1;
  localparam logic [1:0] REG_NSCALE = 2'd2;

  typedef struct packed {
    logic [MEAN_W-1:0]   mean;        // signed Q4.12
    logic [ESCALE_W-1:0] exp_scale;   // unsigned Q8.16
    logic [NSCALE_W-1:0] norm_scale;  // unsigned Q4.16
  } cfg_t;

  // Front end to divider
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] den;
    logic             last;
  } frac_t;

  // Divider to scaler
  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic               last;
  } ratio_t;

endpackage

// ===== sv/gdre_front.sv =====
// Front end: d = sample - mean, |y| = d*d*exp_scale, clamp, Pade numerator and denominator.
// Five register stages; depends on gdre_pkg.
module gdre_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gdre_pkg::cfg_t                 cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [gdre_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                           last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output gdre_pkg::frac_t                out_o
);
  import gdre_pkg::*;

  logic [FRONT_STAGES-1:0] v_q;
  logic [FRONT_STAGES-1:0] en;
  logic                    l_q [FRONT_STAGES];

  logic [SAMPLE_W:0]   diff;
  logic [SAMPLE_W-1:0] ad_d, ad_q;
  logic [31:0]         sq_d, sq_q;
  logic [55:0]         prod;
  logic [27:0]         mag_d, mag_q;
  logic [MAG_W-1:0]    magc;
  logic [MAG_W-1:0]    pa_d, pa_q, pb_d, pb_q;
  logic [REM_W-1:0]    sqa, sqb;
  logic [NUM_W-1:0]    num_d, num_q, den_d, den_q;

  // Stage enables: a stage loads when empty or when the next one moves
  always_comb begin
    en[FRONT_STAGES-1] = !v_q[FRONT_STAGES-1] || out_ready_i;
    for (int k = FRONT_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < FRONT_STAGES; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) l_q[0] <= last_i;
    for (int k = 1; k < FRONT_STAGES; k++) begin
      if (en[k]) l_q[k] <= l_q[k-1];
    end
  end

  // Stage 1: difference and magnitude
  always_comb begin
    diff = {sample_i[SAMPLE_W-1], sample_i} - {cfg_i.mean[MEAN_W-1], cfg_i.mean};
    ad_d = diff[SAMPLE_W] ? SAMPLE_W'(~diff + (SAMPLE_W+1)'(1)) : diff[SAMPLE_W-1:0];
  end

  // Stage 2: square
  assign sq_d = ad_q * ad_q;

  // Stage 3: scale by exp_scale, keep Q.12
  always_comb begin
    prod  = sq_q * cfg_i.exp_scale;
    mag_d = prod[55:28];
  end

  // Stage 4: clamp, then |y+3| and |y-3|
  always_comb begin
    magc = (mag_q > 28'(MAG_MAX)) ? MAG_MAX : mag_q[MAG_W-1:0];
    pa_d = (magc > THREE_Y) ? (magc - THREE_Y) : (THREE_Y - magc);
    pb_d = magc + THREE_Y;
  end

  // Stage 5: squares plus three
  always_comb begin
    sqa   = pa_q * pa_q;
    sqb   = pb_q * pb_q;
    num_d = sqa[NUM_W-1:0] + THREE_SQ;
    den_d = sqb[NUM_W-1:0] + THREE_SQ;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) ad_q  <= ad_d;
    if (en[1]) sq_q  <= sq_d;
    if (en[2]) mag_q <= mag_d;
    if (en[3]) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
    end
    if (en[4]) begin
      num_q <= num_d;
      den_q <= den_d;
    end
  end

  assign out_valid_o = v_q[FRONT_STAGES-1];
  assign out_o.num   = num_q;
  assign out_o.den   = den_q;
  assign out_o.last  = l_q[FRONT_STAGES-1];

endmodule

// ===== sv/gdre_div.sv =====
// Pipelined restoring divider: floor(num * 2^16 / den), one quotient bit per stage.
// Seventeen register stages; depends on gdre_pkg.
module gdre_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  gdre_pkg::frac_t  in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output gdre_pkg::ratio_t out_o
);
  import gdre_pkg::*;

  logic [DIV_STEPS-1:0] v_q;
  logic [DIV_STEPS-1:0] en;
  logic                 l_q   [DIV_STEPS];
  logic [RATIO_W-1:0]   q_q   [DIV_STEPS];
  logic [REM_W-1:0]     r_q   [DIV_STEPS-1];
  logic [NUM_W-1:0]     den_q [DIV_STEPS-1];

  // Stage enables
  always_comb begin
    en[DIV_STEPS-1] = !v_q[DIV_STEPS-1] || out_ready_i;
    for (int k = DIV_STEPS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < DIV_STEPS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) l_q[0] <= in_i.last;
    for (int k = 1; k < DIV_STEPS; k++) begin
      if (en[k]) l_q[k] <= l_q[k-1];
    end
  end

  // One compare and subtract per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [REM_W-1:0]   r_in;
    logic [NUM_W-1:0]   d_in;
    logic [RATIO_W-1:0] q_in;
    logic               ge;
    logic [REM_W-1:0]   rs;

    if (k == 0) begin : g_first
      assign r_in = {1'b0, in_i.num};
      assign d_in = in_i.den;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = r_q[k-1];
      assign d_in = den_q[k-1];
      assign q_in = q_q[k-1];
    end

    assign ge = (r_in >= {1'b0, d_in});
    assign rs = ge ? (r_in - {1'b0, d_in}) : r_in;

    always_ff @(posedge clk_i) begin
      if (en[k]) q_q[k] <= {q_in[RATIO_W-2:0], ge};
    end

    // Remainder and divisor move on except after the final bit
    if (k < DIV_STEPS - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en[k]) begin
          r_q[k]   <= {rs[REM_W-2:0], 1'b0};
          den_q[k] <= d_in;
        end
      end
    end
  end

  assign out_valid_o = v_q[DIV_STEPS-1];
  assign out_o.ratio = q_q[DIV_STEPS-1];
  assign out_o.last  = l_q[DIV_STEPS-1];

endmodule

// ===== sv/gdre_scale.sv =====
// Output scaler: density = min(ratio * norm_scale >> 16, max), held in the output register.
// Two register stages; depends on gdre_pkg.
module gdre_scale (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [gdre_pkg::NSCALE_W-1:0] norm_scale_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  gdre_pkg::ratio_t            in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [gdre_pkg::DENS_W-1:0] density_o,
  output logic                        last_o
);
  import gdre_pkg::*;

  localparam int unsigned PROD_W = RATIO_W + NSCALE_W;

  logic [SCALE_STAGES-1:0] v_q;
  logic [SCALE_STAGES-1:0] en;
  logic                    l_q [SCALE_STAGES];
  logic [PROD_W-1:0]       prod_d, prod_q;
  logic [PROD_W-17:0]      sh;
  logic [DENS_W-1:0]       dens_d, dens_q;

  always_comb begin
    en[SCALE_STAGES-1] = !v_q[SCALE_STAGES-1] || out_ready_i;
    for (int k = SCALE_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < SCALE_STAGES; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Multiply, then drop 16 fraction bits and saturate
  always_comb begin
    prod_d = in_i.ratio * norm_scale_i;
    sh     = prod_q[PROD_W-1:16];
    dens_d = (sh > (PROD_W-16)'(DENS_MAX)) ? DENS_MAX : sh[DENS_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      prod_q <= prod_d;
      l_q[0] <= in_i.last;
    end
    if (en[1]) begin
      dens_q <= dens_d;
      l_q[1] <= l_q[0];
    end
  end

  assign out_valid_o = v_q[SCALE_STAGES-1];
  assign density_o   = dens_q;
  assign last_o      = l_q[SCALE_STAGES-1];

endmodule

// ===== sv/gaussian_density_rational_exp.sv =====
// Gaussian density with a rational (Pade [2/2]) exponential. Each input word carries one
// signed Q4.12 sample; each output word carries its density in unsigned Q4.16, saturated,
// with tlast copied through. The block takes one word every cycle when the output is not
// stalled. Five stages form the Pade numerator and denominator, seventeen stages run the
// restoring divider at one quotient bit each, and two stages scale by norm_scale into the
// output register. Backpressure ripples back stage by stage, so empty stages still fill
// while the output waits. Write mean, exp_scale and norm_scale over the APB port only
// while no word is in flight.
// Depends on gdre_pkg, gdre_front, gdre_div and gdre_scale.
module gaussian_density_rational_exp (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Sample stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  input  logic        s_axis_tlast,   // is_last
  // Density stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [19:0] density, [23:20] zero
  output logic        m_axis_tlast,   // last
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gdre_pkg::*;

  cfg_t            cfg_q;
  logic            wr_en;
  logic            f_valid, f_ready, d_valid, d_ready;
  frac_t           f_data;
  ratio_t          d_data;
  logic [DENS_W-1:0] density;

  // Register writes
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mean       <= '0;
      cfg_q.exp_scale  <= 24'd32768;
      cfg_q.norm_scale <= 20'd26145;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_MEAN:   cfg_q.mean       <= pwdata[MEAN_W-1:0];
        REG_ESCALE: cfg_q.exp_scale  <= pwdata[ESCALE_W-1:0];
        REG_NSCALE: cfg_q.norm_scale <= pwdata[NSCALE_W-1:0];
        default:    ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (paddr[3:2])
      REG_MEAN:   prdata = {16'b0, cfg_q.mean};
      REG_ESCALE: prdata = {8'b0, cfg_q.exp_scale};
      REG_NSCALE: prdata = {12'b0, cfg_q.norm_scale};
      default:    prdata = '0;
    endcase
  end

  gdre_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .sample_i    (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_o       (f_data)
  );

  gdre_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_i        (f_data),
    .out_valid_o (d_valid),
    .out_ready_i (d_ready),
    .out_o       (d_data)
  );

  gdre_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .norm_scale_i (cfg_q.norm_scale),
    .in_valid_i   (d_valid),
    .in_ready_o   (d_ready),
    .in_i         (d_data),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .density_o    (density),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, density};

endmodule

// ===== sv/gdre_checker.sv =====
// Port-level checks for the Gaussian density block, bound to the top level.
// Depends on gdre_pkg and gaussian_density_rational_exp.
module gdre_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);
  import gdre_pkg::*;

  // Output stream comes up empty after reset
  a_reset_empty: assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output word valid right after reset");

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output word changed");

  // Padding above the density stays zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:20] == 4'h0)
    else $error("output padding bits set");

  // A norm_scale write reads back on the next cycle
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && paddr[3:2] == REG_NSCALE) ##1
      (psel && !pwrite && paddr[3:2] == REG_NSCALE) |->
      prdata == {12'b0, $past(pwdata[19:0])})
    else $error("norm_scale readback mismatch");

endmodule

bind gaussian_density_rational_exp gdre_checker u_gdre_checker (.*);
